// File: hw/rtl/qite_pkg.sv
// Shared types and codes for the quad index table engine.
// Holds the transfer payload structs, command and status codes, and default sizes.
// No dependencies.
package qite_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int DEF_MAX_ENTRIES     = 256;
  localparam int DEF_ATOM_INDEX_BITS = 16;

  // Fixed payload field widths
  localparam int ATOM_FIELD_W  = 16;
  localparam int CMD_FIELD_W   = 2;
  localparam int STAT_FIELD_W  = 2;
  localparam int INDEX_FIELD_W = 8;
  localparam int COUNT_FIELD_W = 9;

  // Command codes
  localparam logic [CMD_FIELD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_FIELD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_FIELD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_FIELD_W-1:0] CMD_PURGE  = 2'd3;

  // Status codes
  localparam logic [STAT_FIELD_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_FIELD_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_FIELD_W-1:0] STAT_DUPLICATE = 2'd2;
  localparam logic [STAT_FIELD_W-1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [CMD_FIELD_W-1:0]  cmd;
    logic [ATOM_FIELD_W-1:0] atom_first;
    logic [ATOM_FIELD_W-1:0] atom_second;
    logic [ATOM_FIELD_W-1:0] atom_third;
    logic [ATOM_FIELD_W-1:0] atom_fourth;
  } in_item_t;

  typedef struct packed {
    logic [STAT_FIELD_W-1:0]  status;
    logic [INDEX_FIELD_W-1:0] entry_index;
    logic [COUNT_FIELD_W-1:0] entry_count;
    logic [COUNT_FIELD_W-1:0] removed;
  } out_item_t;

  // Per-cell control: rotate one step toward slot 0, or load a new tuple
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// File: hw/rtl/qite_cell.sv
// One storage cell of the tuple chain: holds one four-atom tuple.
// Rotates in its neighbor's tuple or loads a new one. Depends on qite_pkg.
module qite_cell import qite_pkg::*; #(
  parameter int TUPLE_W = 4 * DEF_ATOM_INDEX_BITS
) (
  input  logic               clk_i,
  input  cell_ctl_t          ctl_i,
  input  logic [TUPLE_W-1:0] nbr_tuple_i,
  input  logic [TUPLE_W-1:0] load_tuple_i,
  output logic [TUPLE_W-1:0] tuple_o
);

  logic [TUPLE_W-1:0] tuple_q;
  logic [TUPLE_W-1:0] tuple_d;

  // Load wins over shift; the sequencer never asks for both
  always_comb begin
    tuple_d = tuple_q;
    if (ctl_i.load) begin
      tuple_d = load_tuple_i;
    end else if (ctl_i.shift) begin
      tuple_d = nbr_tuple_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tuple_q <= tuple_d;
  end

  assign tuple_o = tuple_q;

endmodule

// File: hw/rtl/qite_ctrl.sv
// Command sequencer of the quad index table engine: scans the rotating chain
// at its head cell, applies find, add, delete and purge, and holds the result register.
// Depends on qite_pkg.
module qite_ctrl import qite_pkg::*; #(
  parameter  int MAX_ENTRIES     = DEF_MAX_ENTRIES,
  parameter  int ATOM_INDEX_BITS = DEF_ATOM_INDEX_BITS,
  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1),
  localparam int TUPLE_W = 4 * ATOM_INDEX_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic [TUPLE_W-1:0] head_tuple_i,
  output cell_ctl_t          chain_ctl_o,
  output logic [IDX_W-1:0]   load_slot_o,
  output logic [TUPLE_W-1:0] load_tuple_o,
  output logic [CNT_W-1:0]   fill_o
);

  localparam int A = ATOM_INDEX_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_APPLY  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        fill_q, fill_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_item_q, out_item_d;
  logic [IDX_W-1:0]        cnt_q, cnt_d;
  logic [CMD_FIELD_W-1:0]  cmd_q, cmd_d;
  logic [TUPLE_W-1:0]      query_q, query_d;
  logic                    hit_q, hit_d;
  logic [IDX_W-1:0]        hit_idx_q, hit_idx_d;
  logic [TUPLE_W-1:0]      last_q, last_d;
  logic [CNT_W-1:0]        removed_q, removed_d;
  logic [STAT_FIELD_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]        index_q, index_d;

  logic [A-1:0]       q0, q1, q2, q3;
  logic [A-1:0]       h0, h1, h2, h3;
  logic [TUPLE_W-1:0] rev_query;
  logic               tuple_eq;
  logic               has_atom;
  logic               slot_match;
  logic               in_range;
  logic               at_last;
  logic               hit_at_last;

  // Split query and head tuple into atoms (atom 0 in the low bits)
  assign q0 = query_q[0*A +: A];
  assign q1 = query_q[1*A +: A];
  assign q2 = query_q[2*A +: A];
  assign q3 = query_q[3*A +: A];
  assign h0 = head_tuple_i[0*A +: A];
  assign h1 = head_tuple_i[1*A +: A];
  assign h2 = head_tuple_i[2*A +: A];
  assign h3 = head_tuple_i[3*A +: A];

  // Compare the head slot against the query, forward or reversed; a purge matches on the first atom
  assign rev_query  = {q0, q1, q2, q3};
  assign tuple_eq   = (head_tuple_i == query_q) || (head_tuple_i == rev_query);
  assign has_atom   = (h0 == q0) || (h1 == q0) || (h2 == q0) || (h3 == q0);
  assign slot_match = (cmd_q == CMD_PURGE) ? has_atom : tuple_eq;

  assign in_range    = CNT_W'(cnt_q) < fill_q;
  assign at_last     = CNT_W'(cnt_q) == (fill_q - ONE_CNT);
  assign hit_at_last = CNT_W'(hit_idx_q) == (fill_q - ONE_CNT);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;
    cnt_d        = cnt_q;
    cmd_d        = cmd_q;
    query_d      = query_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    last_d       = last_q;
    removed_d    = removed_q;
    status_d     = status_q;
    index_d      = index_q;
    chain_ctl_o  = '0;
    load_slot_o  = hit_idx_q;
    load_tuple_o = last_q;

    // Drop the result once its transfer completes
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = in_item_i.cmd;
          query_d   = {A'(in_item_i.atom_fourth), A'(in_item_i.atom_third),
                       A'(in_item_i.atom_second), A'(in_item_i.atom_first)};
          cnt_d     = '0;
          hit_d     = 1'b0;
          hit_idx_d = '0;
          removed_d = '0;
          state_d   = ST_SCAN;
        end
      end

      // Rotate the whole chain once; slot cnt_q sits in the head cell
      ST_SCAN: begin
        chain_ctl_o.shift = 1'b1;
        if (in_range && slot_match && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = cnt_q;
        end
        if (in_range && at_last) begin
          last_d = head_tuple_i;
        end
        if (cnt_q == LAST_STEP) begin
          state_d = ST_APPLY;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end

      ST_APPLY: begin
        status_d = STAT_OK;
        index_d  = '0;
        state_d  = ST_FINISH;
        case (cmd_q)
          CMD_FIND: begin
            if (hit_q) begin
              index_d = hit_idx_q;
            end else begin
              status_d = STAT_NOT_FOUND;
            end
          end
          CMD_ADD: begin
            if (hit_q) begin
              status_d = STAT_DUPLICATE;
              index_d  = hit_idx_q;
            end else if (fill_q == FULL_CNT) begin
              status_d = STAT_FULL;
            end else begin
              chain_ctl_o.load = 1'b1;
              load_slot_o      = IDX_W'(fill_q);
              load_tuple_o     = query_q;
              index_d          = IDX_W'(fill_q);
              fill_d           = fill_q + ONE_CNT;
            end
          end
          CMD_DELETE: begin
            if (hit_q) begin
              chain_ctl_o.load = !hit_at_last;
              index_d          = hit_idx_q;
              fill_d           = fill_q - ONE_CNT;
              removed_d        = ONE_CNT;
            end else begin
              status_d = STAT_NOT_FOUND;
            end
          end
          default: begin
            // Purge: move the last entry into the hit slot, then rescan
            if (hit_q) begin
              chain_ctl_o.load = !hit_at_last;
              fill_d           = fill_q - ONE_CNT;
              removed_d        = removed_q + ONE_CNT;
              cnt_d            = '0;
              hit_d            = 1'b0;
              state_d          = ST_SCAN;
            end
          end
        endcase
      end

      // Hand the result over once the output register is free
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_item_d.status      = status_q;
          out_item_d.entry_index = INDEX_FIELD_W'(index_q);
          out_item_d.entry_count = COUNT_FIELD_W'(fill_q);
          out_item_d.removed     = COUNT_FIELD_W'(removed_q);
          state_d                = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working payload registers
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    cnt_q      <= cnt_d;
    cmd_q      <= cmd_d;
    query_q    <= query_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    last_q     <= last_d;
    removed_q  <= removed_d;
    status_q   <= status_d;
    index_q    <= index_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign fill_o      = fill_q;

endmodule

// File: hw/rtl/quad_index_table_engine_top.sv
// Top level of the quad index table engine: a ring of tuple cells plus the
// command sequencer. Depends on qite_pkg, qite_cell and qite_ctrl.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+-----------
//   in      | input     | in_valid_i / in_stall_o     | in_item_i
//   out     | output    | out_valid_o / out_stall_i   | out_item_o
//
// Find, add and delete rotate the ring of MAX_ENTRIES cells once past the head
// cell, one slot per cycle, then apply the command and hand the result over.
// A purge that removes r entries makes r + 1 passes.
// Reset clears the fill count, state and result valid; cells hold undefined tuples until written.
// One command is in work at a time; a result held by out_stall_i does not block
// the next accept, only the hand-over of the following result.
module quad_index_table_engine_top import qite_pkg::*; #(
  parameter int MAX_ENTRIES     = DEF_MAX_ENTRIES,
  parameter int ATOM_INDEX_BITS = DEF_ATOM_INDEX_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int TUPLE_W = 4 * ATOM_INDEX_BITS;

  logic [TUPLE_W-1:0] cell_tuple [MAX_ENTRIES];
  cell_ctl_t          chain_ctl;
  logic [IDX_W-1:0]   load_slot;
  logic [TUPLE_W-1:0] load_tuple;
  logic [CNT_W-1:0]   fill_count;

  qite_ctrl #(
    .MAX_ENTRIES     (MAX_ENTRIES),
    .ATOM_INDEX_BITS (ATOM_INDEX_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o),
    .head_tuple_i (cell_tuple[0]),
    .chain_ctl_o  (chain_ctl),
    .load_slot_o  (load_slot),
    .load_tuple_o (load_tuple),
    .fill_o       (fill_count)
  );

  // Ring of cells: each takes its upper neighbor, the top one wraps to slot 0
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    cell_ctl_t cell_ctl;

    // Decode the single-slot write
    assign cell_ctl.shift = chain_ctl.shift;
    assign cell_ctl.load  = chain_ctl.load && (load_slot == IDX_W'(k));

    qite_cell #(
      .TUPLE_W (TUPLE_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (cell_ctl),
      .nbr_tuple_i  (cell_tuple[(k + 1) % MAX_ENTRIES]),
      .load_tuple_i (load_tuple),
      .tuple_o      (cell_tuple[k])
    );
  end

`ifndef ASSERT_OFF
  // Fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_count <= CNT_W'(MAX_ENTRIES))
    else $error("fill count above table size");

  // An accepted command keeps the input stalled in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // A new result only follows a command in work
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a command in work");

  // The table does not change while idle
  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> $stable(fill_count))
    else $error("fill count changed while idle");
`endif

endmodule
